/* design/smr_pkg.sv */
// Shared types and constants for the spiral matrix reorder block.
`timescale 1ns / 1ps

package smr_pkg;

	localparam int MAX_ROWS        = 16;
	localparam int MAX_COLS        = 16;
	localparam int DATA_WIDTH_DEF  = 32;
	localparam int STORE_DEPTH     = MAX_ROWS * MAX_COLS;
	localparam int ROW_W           = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int COL_W           = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int ADDR_W          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int CNT_W           = $clog2(STORE_DEPTH + 1);
	localparam int SIZE_W          = 5;
	localparam int RING_W          = 3;
	localparam int CFG_IDX_W       = 1;
	localparam int QUEUE_DEPTH     = 2;

	typedef enum logic {
		CMD_LOAD  = 1'b0,
		CMD_FETCH = 1'b1
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROW_COUNT = 1'b0,
		REG_COL_COUNT = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		DIR_RIGHT = 2'd0,
		DIR_DOWN  = 2'd1,
		DIR_LEFT  = 2'd2,
		DIR_UP    = 2'd3
	} dir_t;

	typedef struct packed {
		cmd_t              op;
		logic [ADDR_W-1:0] addr;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
		logic              last;
	} smr_entry_t;

endpackage

/* design/smr_front.sv */
// Front end: takes items, holds the load pointer and spiral walker, issues store ops.
`timescale 1ns / 1ps

module smr_front import smr_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [SIZE_W-1:0]     cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  command,
	input  logic [DATA_WIDTH-1:0] in_value,
	output logic                  push,
	output smr_entry_t            push_entry,
	output logic [DATA_WIDTH-1:0] push_data,
	input  logic                  q_ready
);

	function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
		input logic [SIZE_W:0] hi);
		logic [SIZE_W-1:0] r;
		r = v;
		if (v == '0)
			r = SIZE_W'(1);
		else if ({1'b0, v} > hi)
			r = SIZE_W'(hi);
		return r;
	endfunction

	logic [SIZE_W-1:0]   rows_q, cols_q;
	logic [ADDR_W-1:0]   load_ptr_q, emit_q;
	logic [ROW_W-1:0]    cur_row_q, row_n;
	logic [COL_W-1:0]    cur_col_q, col_n;
	logic [RING_W-1:0]   ring_q, ring_n;
	dir_t                dir_q, dir_n;
	logic [CNT_W-1:0]    total;
	logic [CNT_W-1:0]    load_next, emit_next;
	logic                load_wrap, emit_last;
	logic [SIZE_W-1:0]   bottom, right, top_p1, ring_ext;
	logic [ROW_W+SIZE_W-1:0] fetch_addr;
	logic                accept, fetch;

	assign total      = CNT_W'(rows_q) * CNT_W'(cols_q);
	assign load_next  = CNT_W'(load_ptr_q) + CNT_W'(1);
	assign emit_next  = CNT_W'(emit_q) + CNT_W'(1);
	assign load_wrap  = load_next >= total;
	assign emit_last  = emit_next >= total;
	assign fetch_addr = (ROW_W+SIZE_W)'(cur_row_q) * (ROW_W+SIZE_W)'(cols_q)
		+ (ROW_W+SIZE_W)'(cur_col_q);

	assign in_ready = q_ready;
	assign accept   = in_valid && in_ready;
	assign fetch    = cmd_t'(command) == CMD_FETCH;

	assign ring_ext = SIZE_W'(ring_q);
	assign bottom   = rows_q - SIZE_W'(1) - ring_ext;
	assign right    = cols_q - SIZE_W'(1) - ring_ext;
	assign top_p1   = ring_ext + SIZE_W'(1);

	always_comb begin
		push              = accept;
		push_data         = in_value;
		push_entry.op     = fetch ? CMD_FETCH : CMD_LOAD;
		push_entry.addr   = fetch ? ADDR_W'(fetch_addr) : load_ptr_q;
		push_entry.row    = cur_row_q;
		push_entry.col    = cur_col_q;
		push_entry.last   = emit_last;
	end

	// next spiral position, stepping into the next ring once the current one is done
	always_comb begin
		row_n  = cur_row_q;
		col_n  = cur_col_q;
		dir_n  = dir_q;
		ring_n = ring_q;
		case (dir_q)
			DIR_RIGHT: begin
				if (SIZE_W'(cur_col_q) < right) begin
					col_n = cur_col_q + COL_W'(1);
				end else begin
					dir_n = DIR_DOWN;
					row_n = cur_row_q + ROW_W'(1);
				end
			end
			DIR_DOWN: begin
				if (SIZE_W'(cur_row_q) < bottom) begin
					row_n = cur_row_q + ROW_W'(1);
				end else begin
					dir_n = DIR_LEFT;
					col_n = cur_col_q - COL_W'(1);
				end
			end
			DIR_LEFT: begin
				if (SIZE_W'(cur_col_q) > ring_ext) begin
					col_n = cur_col_q - COL_W'(1);
				end else if (SIZE_W'(cur_row_q) > top_p1) begin
					dir_n = DIR_UP;
					row_n = cur_row_q - ROW_W'(1);
				end else begin
					ring_n = ring_q + RING_W'(1);
					row_n  = ROW_W'(ring_n);
					col_n  = COL_W'(ring_n);
					dir_n  = DIR_RIGHT;
				end
			end
			DIR_UP: begin
				if (SIZE_W'(cur_row_q) > top_p1) begin
					row_n = cur_row_q - ROW_W'(1);
				end else begin
					ring_n = ring_q + RING_W'(1);
					row_n  = ROW_W'(ring_n);
					col_n  = COL_W'(ring_n);
					dir_n  = DIR_RIGHT;
				end
			end
			default: begin
				dir_n = DIR_RIGHT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q     <= SIZE_W'(MAX_ROWS > 16 ? 16 : MAX_ROWS);
			cols_q     <= SIZE_W'(MAX_COLS > 16 ? 16 : MAX_COLS);
			load_ptr_q <= '0;
			emit_q     <= '0;
			cur_row_q  <= '0;
			cur_col_q  <= '0;
			ring_q     <= '0;
			dir_q      <= DIR_RIGHT;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_ROW_COUNT: rows_q <= clamp_size(cfg_data, (SIZE_W+1)'(MAX_ROWS));
				REG_COL_COUNT: cols_q <= clamp_size(cfg_data, (SIZE_W+1)'(MAX_COLS));
				default: ;
			endcase
			load_ptr_q <= '0;
			emit_q     <= '0;
			cur_row_q  <= '0;
			cur_col_q  <= '0;
			ring_q     <= '0;
			dir_q      <= DIR_RIGHT;
		end else if (accept && !fetch) begin
			load_ptr_q <= load_wrap ? '0 : ADDR_W'(load_next);
		end else if (accept && emit_last) begin
			emit_q    <= '0;
			cur_row_q <= '0;
			cur_col_q <= '0;
			ring_q    <= '0;
			dir_q     <= DIR_RIGHT;
		end else if (accept) begin
			emit_q    <= ADDR_W'(emit_next);
			cur_row_q <= row_n;
			cur_col_q <= col_n;
			ring_q    <= ring_n;
			dir_q     <= dir_n;
		end
	end

`ifndef ASSERT_OFF
	a_pos_in_matrix: assert property (@(posedge clk) disable iff (!arst_n)
		(SIZE_W'(cur_row_q) < rows_q) && (SIZE_W'(cur_col_q) < cols_q))
		else $error("spiral position outside matrix");
	a_emit_below_total: assert property (@(posedge clk) disable iff (!arst_n)
		CNT_W'(emit_q) < total)
		else $error("emit count reached total");
	a_load_below_total: assert property (@(posedge clk) disable iff (!arst_n)
		CNT_W'(load_ptr_q) < total)
		else $error("load pointer reached total");
`endif

endmodule

/* design/smr_queue.sv */
// Short FIFO of store ops between the front end and the back end.
`timescale 1ns / 1ps

module smr_queue import smr_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  smr_entry_t            push_entry,
	input  logic [DATA_WIDTH-1:0] push_data,
	output logic                  q_ready,
	output logic                  q_valid,
	output smr_entry_t            head_entry,
	output logic [DATA_WIDTH-1:0] head_data,
	input  logic                  pop
);

	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	smr_entry_t            entry_q [QUEUE_DEPTH];
	logic [DATA_WIDTH-1:0] data_q  [QUEUE_DEPTH];
	logic [QPTR_W-1:0]     wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]     count_q;
	logic                  do_pop;

	assign q_ready    = count_q != QCNT_W'(QUEUE_DEPTH);
	assign q_valid    = count_q != '0;
	assign head_entry = entry_q[rd_ptr_q];
	assign head_data  = data_q[rd_ptr_q];
	assign do_pop     = pop && q_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_entry;
			data_q[wr_ptr_q]  <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			if (push && !do_pop)
				count_q <= count_q + QCNT_W'(1);
			else if (!push && do_pop)
				count_q <= count_q - QCNT_W'(1);
		end
	end

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue count beyond depth");
`endif

endmodule

/* design/smr_back.sv */
// Back end: element store, load writes, fetch reads and the result register.
`timescale 1ns / 1ps

module smr_back import smr_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	input  smr_entry_t            head_entry,
	input  logic [DATA_WIDTH-1:0] head_data,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [DATA_WIDTH-1:0] out_value,
	output logic [ROW_W-1:0]      out_row,
	output logic [COL_W-1:0]      out_col,
	output logic                  is_last
);

	logic [DATA_WIDTH-1:0] mem_q [STORE_DEPTH];
	logic                  valid_s1;
	logic [DATA_WIDTH-1:0] value_s1;
	logic [ROW_W-1:0]      row_s1;
	logic [COL_W-1:0]      col_s1;
	logic                  last_s1;
	logic                  is_fetch;

	assign is_fetch = head_entry.op == CMD_FETCH;
	// loads never wait on the result register
	assign pop = q_valid && (!is_fetch || !valid_s1 || out_ready);

	always_ff @(posedge clk) begin
		if (pop && !is_fetch)
			mem_q[head_entry.addr] <= head_data;
		if (pop && is_fetch) begin
			value_s1 <= mem_q[head_entry.addr];
			row_s1   <= head_entry.row;
			col_s1   <= head_entry.col;
			last_s1  <= head_entry.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (pop && is_fetch)
			valid_s1 <= 1'b1;
		else if (out_ready)
			valid_s1 <= 1'b0;
	end

	assign out_valid = valid_s1;
	assign out_value = value_s1;
	assign out_row   = row_s1;
	assign out_col   = col_s1;
	assign is_last   = last_s1;

`ifndef ASSERT_OFF
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !out_ready) |=> $stable(value_s1) && $stable(row_s1))
		else $error("pending result overwritten");
`endif

endmodule

/* design/spiral_matrix_reorder.sv */
// Spiral matrix reorder top level: front end, op queue and element store.
// Loads (command 0) fill a row_count x col_count matrix in row-major order; fetches
// (command 1) return the elements in clockwise spiral order with their row, column and
// an is_last flag on the final one. Both pointers wrap after rows*cols items, and a
// write to either size register restarts them while keeping stored data. One item is
// taken per cycle while the op queue has room; the rate is set by the single-port
// element store, which does one write or one read a cycle. A fetch result reaches
// the output through a queue slot and then the registered store read. While
// a result waits on out_ready, loads still drain into the store; once a fetch reaches
// the head of the two-entry queue it holds there, one more item can enter behind it
// and in_ready then drops. Only fetch elements that were loaded earlier; the store is
// not cleared at reset.
`timescale 1ns / 1ps

module spiral_matrix_reorder import smr_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [SIZE_W-1:0]     cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  command,
	input  logic [DATA_WIDTH-1:0] in_value,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [DATA_WIDTH-1:0] out_value,
	output logic [ROW_W-1:0]      out_row,
	output logic [COL_W-1:0]      out_col,
	output logic                  is_last
);

	logic                  push, q_ready, q_valid, pop;
	smr_entry_t            push_entry, head_entry;
	logic [DATA_WIDTH-1:0] push_data, head_data;

	smr_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.command    (command),
		.in_value   (in_value),
		.push       (push),
		.push_entry (push_entry),
		.push_data  (push_data),
		.q_ready    (q_ready)
	);

	smr_queue #(.DATA_WIDTH(DATA_WIDTH)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.push_data  (push_data),
		.q_ready    (q_ready),
		.q_valid    (q_valid),
		.head_entry (head_entry),
		.head_data  (head_data),
		.pop        (pop)
	);

	smr_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.head_entry (head_entry),
		.head_data  (head_data),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_value  (out_value),
		.out_row    (out_row),
		.out_col    (out_col),
		.is_last    (is_last)
	);

endmodule

/* bench/spiral_matrix_reorder_test.sv */
// Self-checking bench for the spiral matrix reorder block: directed items, then random phases.
`timescale 1ns / 1ps

module spiral_matrix_reorder_test;
	import smr_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 8;
	localparam int RANDOM_ITEMS = 450;
	localparam int CALM_FROM    = 380;
	localparam logic [DATA_WIDTH_DEF-1:0] CORNERS [4] = '{
		32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h0000_0000
	};

	typedef struct packed {
		logic [DATA_WIDTH_DEF-1:0] value;
		logic [ROW_W-1:0]          row;
		logic [COL_W-1:0]          col;
		logic                      is_end;
	} spiral_elem_t;

	typedef enum logic {
		ROW_CFG,
		ROW_ITEM
	} row_kind_t;

	typedef struct {
		row_kind_t                 kind;
		reg_idx_t                  sel;
		logic [SIZE_W-1:0]         size;
		cmd_t                      cmd;
		logic [DATA_WIDTH_DEF-1:0] value;
		bit                        typed;
		spiral_elem_t              want;
	} plan_row_t;

	logic                      clk       = 1'b0;
	logic                      arst_n    = 1'b0;
	logic                      cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]      cfg_index = '0;
	logic [SIZE_W-1:0]         cfg_data  = '0;
	logic                      in_valid  = 1'b0;
	logic                      in_ready;
	logic                      command   = 1'b0;
	logic [DATA_WIDTH_DEF-1:0] in_value  = '0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic [DATA_WIDTH_DEF-1:0] out_value;
	logic [ROW_W-1:0]          out_row;
	logic [COL_W-1:0]          out_col;
	logic                      is_last;

	// matrix model
	logic [DATA_WIDTH_DEF-1:0] mat_store [STORE_DEPTH];
	bit                        mat_loaded [STORE_DEPTH];
	int                        rows, cols, load_ptr, emitted, pos_row, pos_col, ring;
	dir_t                      heading;

	spiral_elem_t pending [$];
	plan_row_t    plan [$];
	int           errors     = 0;
	int           cycles     = 0;
	int           stall_left = 0;
	bit           calm       = 1'b0;

	spiral_matrix_reorder i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.in_value  (in_value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_value (out_value),
		.out_row   (out_row),
		.out_col   (out_col),
		.is_last   (is_last)
	);

	always #5 clk = ~clk;

	function automatic int clamp_size(logic [SIZE_W-1:0] v, int hi);
		if (v == 0) return 1;
		if (v > hi) return hi;
		return int'(v);
	endfunction

	function automatic void restart_spiral();
		load_ptr = 0;
		emitted  = 0;
		pos_row  = 0;
		pos_col  = 0;
		heading  = DIR_RIGHT;
		ring     = 0;
	endfunction

	function automatic void set_size(reg_idx_t sel, logic [SIZE_W-1:0] v);
		if (sel == REG_ROW_COUNT) rows = clamp_size(v, MAX_ROWS);
		else cols = clamp_size(v, MAX_COLS);
		restart_spiral();
	endfunction

	function automatic int fetch_addr();
		return (pos_row * cols + pos_col) & (STORE_DEPTH - 1);
	endfunction

	function automatic void next_ring();
		ring++;
		pos_row = ring;
		pos_col = ring;
		heading = DIR_RIGHT;
	endfunction

	// Updates the matrix model; returns 1 when the item yields an element.
	function automatic bit apply_item(cmd_t cmd, logic [DATA_WIDTH_DEF-1:0] value,
		output spiral_elem_t res);
		int total, top, bottom, right;
		total = rows * cols;
		res = '0;
		if (cmd == CMD_LOAD) begin
			mat_store[load_ptr]  = value;
			mat_loaded[load_ptr] = 1'b1;
			load_ptr = (load_ptr + 1 >= total) ? 0 : load_ptr + 1;
			return 1'b0;
		end
		res.value  = mat_store[fetch_addr()];
		res.row    = pos_row[ROW_W-1:0];
		res.col    = pos_col[COL_W-1:0];
		res.is_end = (emitted + 1 >= total);
		if (res.is_end) begin
			emitted = 0;
			pos_row = 0;
			pos_col = 0;
			heading = DIR_RIGHT;
			ring    = 0;
		end else begin
			emitted++;
			top    = ring;
			bottom = rows - 1 - ring;
			right  = cols - 1 - ring;
			case (heading)
				DIR_RIGHT: begin
					if (pos_col < right) begin
						pos_col++;
					end else begin
						heading = DIR_DOWN;
						pos_row++;
					end
				end
				DIR_DOWN: begin
					if (pos_row < bottom) begin
						pos_row++;
					end else begin
						heading = DIR_LEFT;
						pos_col--;
					end
				end
				DIR_LEFT: begin
					if (pos_col > top) begin
						pos_col--;
					end else if (pos_row > top + 1) begin
						heading = DIR_UP;
						pos_row--;
					end else begin
						next_ring();
					end
				end
				default: begin
					if (pos_row > top + 1) pos_row--;
					else next_ring();
				end
			endcase
		end
		return 1'b1;
	endfunction

	function automatic void plan_cfg(reg_idx_t sel, logic [SIZE_W-1:0] v);
		plan_row_t p;
		p.kind  = ROW_CFG;
		p.sel   = sel;
		p.size  = v;
		p.typed = 1'b0;
		plan.insert(plan.size(), p);
	endfunction

	function automatic void plan_load(logic [DATA_WIDTH_DEF-1:0] v);
		plan_row_t p;
		p.kind  = ROW_ITEM;
		p.cmd   = CMD_LOAD;
		p.value = v;
		p.typed = 1'b0;
		p.want  = '0;
		plan.insert(plan.size(), p);
	endfunction

	function automatic void plan_fetch(logic [DATA_WIDTH_DEF-1:0] v, logic [ROW_W-1:0] r,
		logic [COL_W-1:0] c, logic e);
		plan_row_t p;
		p.kind  = ROW_ITEM;
		p.cmd   = CMD_FETCH;
		p.value = $urandom();
		p.typed = 1'b1;
		p.want  = '{value: v, row: r, col: c, is_end: e};
		plan.insert(plan.size(), p);
	endfunction

	task automatic send_item(cmd_t cmd, logic [DATA_WIDTH_DEF-1:0] value, bit typed,
		spiral_elem_t want);
		spiral_elem_t res;
		in_valid <= 1'b1;
		command  <= cmd;
		in_value <= value;
		do @(posedge clk); while (!in_ready);
		if (apply_item(cmd, value, res)) pending.insert(pending.size(), typed ? want : res);
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	// Size writes only once the block has drained.
	task automatic write_size(reg_idx_t sel, logic [SIZE_W-1:0] v);
		in_valid <= 1'b0;
		while (pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= sel;
		cfg_data  <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		set_size(sel, v);
	endtask

	function automatic logic [SIZE_W-1:0] pick_size();
		case ($urandom_range(0, 9))
			0: return SIZE_W'(1);
			1: return SIZE_W'(16);
			2: return SIZE_W'($urandom_range(17, 31));
			3: return SIZE_W'(0);
			default: return SIZE_W'($urandom_range(2, 7));
		endcase
	endfunction

	always @(posedge clk) begin
		if (calm) begin
			out_ready <= 1'b1;
		end else if (stall_left > 0) begin
			out_ready  <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 5) == 0) begin
			out_ready  <= 1'b0;
			stall_left <= $urandom_range(0, 11);
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		spiral_elem_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending.size() == 0) begin
				$error("element with no fetch pending: value %h row %0d col %0d",
					out_value, out_row, out_col);
				errors++;
			end else begin
				want = pending.pop_front();
				if (out_value !== want.value) begin
					$error("out_value: expected %h, got %h", want.value, out_value);
					errors++;
				end
				if (out_row !== want.row) begin
					$error("out_row: expected %0d, got %0d", want.row, out_row);
					errors++;
				end
				if (out_col !== want.col) begin
					$error("out_col: expected %0d, got %0d", want.col, out_col);
					errors++;
				end
				if (is_last !== want.is_end) begin
					$error("is_last: expected %b, got %b", want.is_end, is_last);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		int                        phase_no, total, budget, n, random_sent;
		logic [SIZE_W-1:0]         r, c;
		logic [DATA_WIDTH_DEF-1:0] value;
		cmd_t                      cmd;
		bit                        fill, both;

		// default 16 x 16
		plan_load(32'h7fff_ffff);
		plan_load(32'h8000_0000);
		plan_fetch(32'h7fff_ffff, 0, 0, 1'b0);
		plan_fetch(32'h8000_0000, 0, 1, 1'b0);
		// zero rows reads as one: 1 x 2, spiral and load both wrap
		plan_cfg(REG_ROW_COUNT, 5'd0);
		plan_cfg(REG_COL_COUNT, 5'd2);
		plan_fetch(32'h7fff_ffff, 0, 0, 1'b0);
		plan_fetch(32'h8000_0000, 0, 1, 1'b1);
		plan_fetch(32'h7fff_ffff, 0, 0, 1'b0);
		plan_load(32'hffff_ffff);
		plan_load(32'h0000_0000);
		plan_load(32'h1234_5678);
		plan_fetch(32'h0000_0000, 0, 1, 1'b1);
		plan_fetch(32'h1234_5678, 0, 0, 1'b0);
		// oversized rows clamp to 16: 16 x 1, fetch ahead of any load
		plan_cfg(REG_ROW_COUNT, 5'd31);
		plan_cfg(REG_COL_COUNT, 5'd1);
		plan_fetch(32'h1234_5678, 0, 0, 1'b0);
		// 1 x 1
		plan_cfg(REG_ROW_COUNT, 5'd1);
		plan_cfg(REG_COL_COUNT, 5'd1);
		plan_fetch(32'h1234_5678, 0, 0, 1'b1);
		plan_load(32'h0000_0005);
		plan_fetch(32'h0000_0005, 0, 0, 1'b1);
		// 2 x 2 ring
		plan_cfg(REG_ROW_COUNT, 5'd2);
		plan_cfg(REG_COL_COUNT, 5'd2);
		plan_load(32'h0000_0001);
		plan_load(32'hfedc_ba98);
		plan_load(32'h5555_5555);
		plan_load(32'haaaa_aaaa);
		plan_fetch(32'h0000_0001, 0, 0, 1'b0);
		plan_fetch(32'hfedc_ba98, 0, 1, 1'b0);
		plan_fetch(32'haaaa_aaaa, 1, 1, 1'b0);
		plan_fetch(32'h5555_5555, 1, 0, 1'b1);

		rows = MAX_ROWS;
		cols = MAX_COLS;
		restart_spiral();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) write_size(plan[i].sel, plan[i].size);
			else send_item(plan[i].cmd, plan[i].value, plan[i].typed, plan[i].want);
		end

		random_sent = 0;
		phase_no    = 0;
		while (random_sent < RANDOM_ITEMS) begin
			case (phase_no)
				0: begin
					r = 5'd16;
					c = 5'd16;
				end
				1: begin
					r = 5'd1;
					c = 5'd16;
				end
				2: begin
					r = 5'd16;
					c = 5'd1;
				end
				default: begin
					r = pick_size();
					c = pick_size();
				end
			endcase
			both = (phase_no < 3) || ($urandom_range(0, 3) >= 2);
			if (both || $urandom_range(0, 1) == 0) write_size(REG_ROW_COUNT, r);
			if (both || cols == 0 || !(rows == clamp_size(r, MAX_ROWS) && !both)) begin
				write_size(REG_COL_COUNT, c);
			end
			total  = rows * cols;
			budget = (total <= 40) ? 2 * total + $urandom_range(0, total + 4) : 80;
			// mostly fill-then-drain sequences, with a little noise either way
			for (n = 0; n < budget && random_sent < RANDOM_ITEMS; n++) begin
				fill = (total <= 40) ? (n < total) : ($urandom_range(0, 1) == 0);
				if (fill) cmd = ($urandom_range(0, 9) == 0) ? CMD_FETCH : CMD_LOAD;
				else cmd = ($urandom_range(0, 6) == 0) ? CMD_LOAD : CMD_FETCH;
				if (!mat_loaded[fetch_addr()]) cmd = CMD_LOAD;
				value = $urandom();
				if ($urandom_range(0, 7) == 0) value = CORNERS[$urandom_range(0, 3)];
				send_item(cmd, value, 1'b0, '0);
				random_sent++;
				if (random_sent > CALM_FROM) calm = 1'b1;
			end
			phase_no++;
		end

		in_valid <= 1'b0;
		while (pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && pending.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

/* files.f */
design/smr_pkg.sv
design/smr_front.sv
design/smr_queue.sv
design/smr_back.sv
design/spiral_matrix_reorder.sv
bench/spiral_matrix_reorder_test.sv
